// File: hw/rtl/mic_pkg.sv
// Shared types and constants for the magnetometer iron calibration block.
// Depends on nothing; imported by the top level, the divider and the checker.
`timescale 1ns / 1ps

package mic_pkg;

    // Field widths of the sample and result words.
    localparam int MAG_W   = 16;
    localparam int SCALE_W = 31;
    localparam int FRAC_W  = 16;

    // Largest possible positive half range of one axis.
    localparam int HALF_MAX = 32767;

    // Tracker start values and register reset value.
    localparam logic [MAG_W-1:0]   TRACK_MAX_INIT = 16'h8001;
    localparam logic [MAG_W-1:0]   TRACK_MIN_INIT = 16'h7FFF;
    localparam logic [15:0]        COUNT_RESET    = 16'd1500;
    localparam logic [SCALE_W-1:0] SCALE_SAT      = 31'h7FFF_FFFF;

    // Sequencer states, one-hot.
    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_TRACK  = 6'b000010,
        ST_HALF   = 6'b000100,
        ST_DLOAD  = 6'b001000,
        ST_DWAIT  = 6'b010000,
        ST_FINISH = 6'b100000
    } mic_state_t;

    // Status of the shared divider as seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

// File: hw/rtl/mic_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on mic_pkg for the status struct.
`timescale 1ns / 1ps

module mic_div #(
    parameter int DW   = 33,
    parameter int DENW = 17
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DW-1:0]        dividend,
    input  logic [DENW-1:0]      divisor,
    output logic [DW-1:0]        quotient,
    output mic_pkg::div_status_t status
);
    import mic_pkg::*;

    localparam int CW = (DW > 1) ? $clog2(DW) : 1;

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [DW-1:0]   quo_reg, quo_next;
    logic [DENW-1:0] rem_reg, rem_next;
    logic [DENW-1:0] den_reg, den_next;
    logic [DENW:0]   shifted;
    logic [DENW:0]   trial;
    logic            fits;

    // One restoring step: shift in the next dividend bit and try a subtract.
    assign shifted = {rem_reg, quo_reg[DW-1]};
    assign trial   = shifted - {1'b0, den_reg};
    assign fits    = (shifted >= {1'b0, den_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DW-2:0], fits};
            rem_next = fits ? trial[DENW-1:0] : shifted[DENW-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(DW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state is reset; the datapath is not.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

// File: hw/rtl/magnetometer_iron_calibration.sv
// Timing: a sample word is accepted, then given one min/max compare per axis.
// At the end of a batch, bias and half range are formed one axis at a time; then
// each scale with a positive half range takes one divider pass over a SUMW+16-bit
// dividend (SUMW = 17 for three axes), then the result waits for a free output slot.
// A new sample word is taken only when idle; s_tready is low while one is compared.
// Reset: asynchronous, active low; trackers re-armed, batch length back to 1500.
// Depends on mic_pkg and mic_div.
`timescale 1ns / 1ps

module magnetometer_iron_calibration #(
    parameter int NUM_AXES = 3
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    // s_tdata: mag_x, mag_y, mag_z, 16 bits each, from bit 0 up.
    input  logic                                          s_tvalid,
    output logic                                          s_tready,
    input  logic [((NUM_AXES*mic_pkg::MAG_W+7)/8)*8-1:0]  s_tdata,
    // m_tdata: bias_x, bias_y, bias_z (16 bits each), then scale_x, scale_y,
    // scale_z (31 bits each), from bit 0 up, zero filled to whole bytes.
    output logic                                          m_tvalid,
    input  logic                                          m_tready,
    output logic [((NUM_AXES*(mic_pkg::MAG_W+mic_pkg::SCALE_W)+7)/8)*8-1:0] m_tdata,
    // m_tuser: degenerate.
    output logic                                          m_tuser,
    // Configuration: batch length in sample words.
    input  logic                                          cfg_valid,
    output logic                                          cfg_ready,
    input  logic [15:0]                                   cfg_data
);
    import mic_pkg::*;

    localparam int ODW  = ((NUM_AXES*(MAG_W+SCALE_W)+7)/8)*8;
    localparam int AXW  = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
    localparam int SUMW = $clog2(NUM_AXES*HALF_MAX+1);
    localparam int DW   = SUMW + FRAC_W;

    mic_state_t         state_reg, state_next;
    logic [AXW-1:0]     axis_reg, axis_next;
    logic [15:0]        count_reg, count_next;
    logic [15:0]        seen_reg, seen_next;
    logic [MAG_W-1:0]   max_reg [NUM_AXES];
    logic [MAG_W-1:0]   max_next [NUM_AXES];
    logic [MAG_W-1:0]   min_reg [NUM_AXES];
    logic [MAG_W-1:0]   min_next [NUM_AXES];
    logic [MAG_W-1:0]   sample_reg [NUM_AXES];
    logic [MAG_W-1:0]   sample_next [NUM_AXES];
    logic [MAG_W-1:0]   bias_reg [NUM_AXES];
    logic [MAG_W-1:0]   bias_next [NUM_AXES];
    logic [MAG_W:0]     half_reg [NUM_AXES];
    logic [MAG_W:0]     half_next [NUM_AXES];
    logic [SCALE_W-1:0] scale_reg [NUM_AXES];
    logic [SCALE_W-1:0] scale_next [NUM_AXES];
    logic [SUMW-1:0]    sum_reg, sum_next;
    logic               degen_reg, degen_next;
    logic               mvalid_reg, mvalid_next;
    logic [ODW-1:0]     mdata_reg, mdata_next;
    logic               muser_reg, muser_next;

    logic               last_axis;
    logic               s_accept;
    logic               out_free;
    logic [MAG_W-1:0]   cur_sample, cur_max, cur_min;
    logic               above, below;
    logic [MAG_W:0]     pair_sum, pair_sum_adj;
    logic [MAG_W:0]     pair_diff, pair_diff_adj;
    logic [MAG_W-1:0]   new_bias;
    logic [MAG_W:0]     new_half;
    logic               new_half_pos;
    logic [MAG_W:0]     cur_half;
    logic               cur_half_pos;
    logic [SUMW-1:0]    divisor;
    logic               div_start;
    logic [DW-1:0]      quotient;
    div_status_t        div_status;
    logic [SCALE_W-1:0] sat_scale;
    logic [ODW-1:0]     out_pack;

    assign last_axis = (axis_reg == AXW'(NUM_AXES - 1));
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign out_free  = !mvalid_reg || m_tready;
    assign cfg_ready = 1'b1;

    // Shared signed compare unit for the axis being tracked.
    assign cur_sample = sample_reg[axis_reg];
    assign cur_max    = max_reg[axis_reg];
    assign cur_min    = min_reg[axis_reg];
    assign above      = ($signed(cur_sample) > $signed(cur_max));
    assign below      = ($signed(cur_sample) < $signed(cur_min));

    // Bias and half range of one axis, both halved toward zero.
    assign pair_sum      = {cur_max[MAG_W-1], cur_max} + {cur_min[MAG_W-1], cur_min};
    assign pair_sum_adj  = pair_sum + {{MAG_W{1'b0}}, pair_sum[MAG_W]};
    assign new_bias      = pair_sum_adj[MAG_W:1];
    assign pair_diff     = {cur_max[MAG_W-1], cur_max} - {cur_min[MAG_W-1], cur_min};
    assign pair_diff_adj = pair_diff + {{MAG_W{1'b0}}, pair_diff[MAG_W]};
    assign new_half      = {pair_diff_adj[MAG_W], pair_diff_adj[MAG_W:1]};
    assign new_half_pos  = !new_half[MAG_W] && (|new_half);

    // Divisor is NUM_AXES times the half range of the current axis.
    assign cur_half     = half_reg[axis_reg];
    assign cur_half_pos = !cur_half[MAG_W] && (|cur_half);
    assign divisor      = SUMW'(cur_half[MAG_W-2:0]) * SUMW'(NUM_AXES);
    assign div_start    = (state_reg == ST_DLOAD) && cur_half_pos;

    mic_div #(
        .DW   (DW),
        .DENW (SUMW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({sum_reg, {FRAC_W{1'b0}}}),
        .divisor  (divisor),
        .quotient (quotient),
        .status   (div_status)
    );

    assign sat_scale = (quotient > DW'(SCALE_SAT)) ? SCALE_SAT : quotient[SCALE_W-1:0];

    // Result word packing.
    always_comb
    begin
        out_pack = '0;
        for (int a = 0; a < NUM_AXES; a++)
        begin
            out_pack[a*MAG_W +: MAG_W]                       = bias_reg[a];
            out_pack[NUM_AXES*MAG_W + a*SCALE_W +: SCALE_W] = scale_reg[a];
        end
    end

    // Sequencer and datapath next state.
    always_comb
    begin
        state_next  = state_reg;
        axis_next   = axis_reg;
        count_next  = count_reg;
        seen_next   = seen_reg;
        max_next    = max_reg;
        min_next    = min_reg;
        sample_next = sample_reg;
        bias_next   = bias_reg;
        half_next   = half_reg;
        scale_next  = scale_reg;
        sum_next    = sum_reg;
        degen_next  = degen_reg;
        mvalid_next = mvalid_reg;
        mdata_next  = mdata_reg;
        muser_next  = muser_reg;

        if (cfg_valid && cfg_ready)
        begin
            count_next = cfg_data;
        end

        if (mvalid_reg && m_tready)
        begin
            mvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    for (int a = 0; a < NUM_AXES; a++)
                    begin
                        sample_next[a] = s_tdata[a*MAG_W +: MAG_W];
                    end
                    seen_next  = seen_reg + 16'd1;
                    axis_next  = '0;
                    state_next = ST_TRACK;
                end
            end
            ST_TRACK:
            begin
                if (above)
                begin
                    max_next[axis_reg] = cur_sample;
                end
                if (below)
                begin
                    min_next[axis_reg] = cur_sample;
                end
                if (last_axis)
                begin
                    axis_next = '0;
                    if (seen_reg < count_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        sum_next   = '0;
                        degen_next = 1'b0;
                        state_next = ST_HALF;
                    end
                end
                else
                begin
                    axis_next = axis_reg + 1'b1;
                end
            end
            ST_HALF:
            begin
                bias_next[axis_reg] = new_bias;
                half_next[axis_reg] = new_half;
                if (new_half_pos)
                begin
                    sum_next = sum_reg + SUMW'(new_half[MAG_W-2:0]);
                end
                else
                begin
                    degen_next = 1'b1;
                end
                if (last_axis)
                begin
                    axis_next  = '0;
                    state_next = ST_DLOAD;
                end
                else
                begin
                    axis_next = axis_reg + 1'b1;
                end
            end
            ST_DLOAD:
            begin
                if (cur_half_pos)
                begin
                    state_next = ST_DWAIT;
                end
                else
                begin
                    // A zero or negative half range gives a zero scale.
                    scale_next[axis_reg] = '0;
                    if (last_axis)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        axis_next = axis_reg + 1'b1;
                    end
                end
            end
            ST_DWAIT:
            begin
                if (div_status.done)
                begin
                    scale_next[axis_reg] = sat_scale;
                    if (last_axis)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        axis_next  = axis_reg + 1'b1;
                        state_next = ST_DLOAD;
                    end
                end
            end
            ST_FINISH:
            begin
                // Hand the result to the output register and re-arm the trackers.
                if (out_free)
                begin
                    mdata_next  = out_pack;
                    muser_next  = degen_reg;
                    mvalid_next = 1'b1;
                    seen_next   = '0;
                    for (int a = 0; a < NUM_AXES; a++)
                    begin
                        max_next[a] = TRACK_MAX_INIT;
                        min_next[a] = TRACK_MIN_INIT;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and tracker state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            axis_reg   <= '0;
            count_reg  <= COUNT_RESET;
            seen_reg   <= '0;
            mvalid_reg <= 1'b0;
            for (int a = 0; a < NUM_AXES; a++)
            begin
                max_reg[a] <= TRACK_MAX_INIT;
                min_reg[a] <= TRACK_MIN_INIT;
            end
        end
        else
        begin
            state_reg  <= state_next;
            axis_reg   <= axis_next;
            count_reg  <= count_next;
            seen_reg   <= seen_next;
            mvalid_reg <= mvalid_next;
            max_reg    <= max_next;
            min_reg    <= min_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
        bias_reg   <= bias_next;
        half_reg   <= half_next;
        scale_reg  <= scale_next;
        sum_reg    <= sum_next;
        degen_reg  <= degen_next;
        mdata_reg  <= mdata_next;
        muser_reg  <= muser_next;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;
    assign m_tuser  = muser_reg;

endmodule

// File: hw/rtl/mic_checker.sv
// Port-level checks for the magnetometer iron calibration block, bound to the top.
// Depends on mic_pkg and magnetometer_iron_calibration.
`timescale 1ns / 1ps

module mic_checker #(
    parameter int NUM_AXES = 3
) (
    input logic                                          clk,
    input logic                                          rst_n,
    input logic                                          s_tvalid,
    input logic                                          s_tready,
    input logic                                          m_tvalid,
    input logic                                          m_tready,
    input logic [((NUM_AXES*(mic_pkg::MAG_W+mic_pkg::SCALE_W)+7)/8)*8-1:0] m_tdata,
    input logic                                          m_tuser
);
    import mic_pkg::*;

    // A result word is held until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result word dropped before it was taken");

    // After a sample word is taken the block is busy tracking it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("sample word taken while the previous one is still tracked");

    // A new result only appears after a busy cycle on the sample side.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result word appeared without a calibration pass");

    // Without a degenerate axis every scale is positive.
    for (genvar a = 0; a < NUM_AXES; a++)
    begin : g_scale
        assert property (@(posedge clk) disable iff (!rst_n)
            (m_tvalid && !m_tuser) |->
                (m_tdata[NUM_AXES*MAG_W + a*SCALE_W +: SCALE_W] != '0))
            else $error("zero scale in a result that is not degenerate");
    end

endmodule

bind magnetometer_iron_calibration mic_checker #(.NUM_AXES(NUM_AXES)) u_mic_checker (.*);

// File: tb/tb.sv
`timescale 1ns / 1ps
// Testbench for magnetometer_iron_calibration: streams three-axis sample words, predicts
// the bias and scale word that closes each batch, and checks every field of it.
// Depends on mic_pkg and the calibration RTL; reads no files.

module tb;
    import mic_pkg::*;

    localparam int AXES          = 3;
    localparam int S_W           = ((AXES*MAG_W+7)/8)*8;
    localparam int M_W           = ((AXES*(MAG_W+SCALE_W)+7)/8)*8;
    localparam int SETTLE_CYCLES = 200;
    localparam int STALL_LIMIT   = 4000;

    typedef logic [AXES-1:0][MAG_W-1:0] sample_t;

    typedef struct packed {
        logic                         degen;
        logic [AXES-1:0][SCALE_W-1:0] scale;
        logic [AXES-1:0][MAG_W-1:0]   bias;
    } calib_t;

    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           s_tvalid  = 1'b0;
    logic           s_tready;
    logic [S_W-1:0] s_tdata   = '0;   // mag_x, mag_y, mag_z from bit 0 up
    logic           m_tvalid;
    logic           m_tready  = 1'b0;
    logic [M_W-1:0] m_tdata;          // bias_x, bias_y, bias_z, scale_x, scale_y, scale_z
    logic           m_tuser;          // degenerate
    logic           cfg_valid = 1'b0;
    logic           cfg_ready;
    logic [15:0]    cfg_data  = '0;

    // Predicted copy of the trackers, the batch counter and the batch length.
    logic signed [MAG_W-1:0] peak_hi [AXES];
    logic signed [MAG_W-1:0] peak_lo [AXES];
    logic [15:0]             batch_fill;
    logic [15:0]             batch_len;

    calib_t      calib_due[$];
    sample_t     pending_samples[$];
    int unsigned fail_count   = 0;
    int unsigned cycle_count  = 0;
    int unsigned quiet_cycles = 0;
    string       axis_tag [AXES] = '{"x", "y", "z"};

    magnetometer_iron_calibration #(
        .NUM_AXES (AXES)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Random back-pressure and gaps, with a calm window that recurs throughout the run.
    function automatic bit take_gap();
        if ((cycle_count % 6000) < 2000)
            return 1'b0;
        return $urandom_range(99) < 14;
    endfunction

    function automatic void rearm_trackers();
        for (int a = 0; a < AXES; a++)
        begin
            peak_hi[a] = TRACK_MAX_INIT;
            peak_lo[a] = TRACK_MIN_INIT;
        end
        batch_fill = '0;
    endfunction

    // Update the trackers with one sample word; at the end of a batch, queue the
    // expected bias, scale and degenerate flag and re-arm.
    task automatic track_sample(input sample_t smp);
        int                hi;
        int                lo;
        int                half [AXES];
        longint unsigned   span_sum;
        longint unsigned   divisor;
        longint unsigned   quot;
        calib_t            res;
        for (int a = 0; a < AXES; a++)
        begin
            if ($signed(smp[a]) > peak_hi[a])
                peak_hi[a] = smp[a];
            if ($signed(smp[a]) < peak_lo[a])
                peak_lo[a] = smp[a];
        end
        batch_fill = batch_fill + 16'd1;
        if (batch_fill < batch_len)
            return;
        span_sum = 0;
        for (int a = 0; a < AXES; a++)
        begin
            hi = peak_hi[a];
            lo = peak_lo[a];
            res.bias[a] = MAG_W'((hi + lo) / 2);
            half[a] = (hi - lo) / 2;
            if (half[a] > 0)
                span_sum += longint'(half[a]);
        end
        res.degen = 1'b0;
        for (int a = 0; a < AXES; a++)
        begin
            if (half[a] <= 0)
            begin
                res.degen = 1'b1;
                res.scale[a] = '0;
            end
            else
            begin
                divisor = longint'(AXES * half[a]);
                quot = (span_sum << FRAC_W) / divisor;
                if (quot > SCALE_SAT)
                    quot = SCALE_SAT;
                res.scale[a] = SCALE_W'(quot);
            end
        end
        calib_due.push_back(res);
        rearm_trackers();
    endtask

    task automatic push_sample(input int x, input int y, input int z);
        pending_samples.push_back({MAG_W'(z), MAG_W'(y), MAG_W'(x)});
    endtask

    // Wait until every sample is taken and every result is back, then let the
    // block finish any sample that closes no batch.
    task automatic drain();
        while (pending_samples.size() != 0 || s_tvalid || calib_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Write the batch length once the block is idle.
    task automatic set_batch(input logic [15:0] len);
        drain();
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= len;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Mostly clustered samples around a drifting center, with some full-range words
    // and field extremes mixed in; a radius of 0 or 1 gives a cluster of half range 0 or 1.
    task automatic random_block(input int count);
        int centre [AXES];
        int radius [AXES];
        int v      [AXES];
        int pick;
        for (int k = 0; k < count; k++)
        begin
            if (k % 48 == 0)
            begin
                for (int a = 0; a < AXES; a++)
                begin
                    centre[a] = int'($urandom_range(40000)) - 20000;
                    case ($urandom_range(3))
                        0:       radius[a] = 0;
                        1:       radius[a] = 1;
                        2:       radius[a] = int'($urandom_range(200, 2));
                        default: radius[a] = int'($urandom_range(32767, 200));
                    endcase
                end
            end
            for (int a = 0; a < AXES; a++)
            begin
                pick = $urandom_range(99);
                if (pick < 10)
                    v[a] = $signed(MAG_W'($urandom));
                else if (pick < 14)
                begin
                    case ($urandom_range(3))
                        0:       v[a] = -32768;
                        1:       v[a] = 32767;
                        2:       v[a] = 0;
                        default: v[a] = -1;
                    endcase
                end
                else
                begin
                    v[a] = centre[a] + int'($urandom_range(2 * radius[a])) - radius[a];
                    if (v[a] > 32767)
                        v[a] = 32767;
                    if (v[a] < -32768)
                        v[a] = -32768;
                end
            end
            push_sample(v[0], v[1], v[2]);
        end
    endtask

    // Sample driver: a word stays on the bus until it is taken.
    always @(posedge clk)
    begin
        if (rst_n && (!s_tvalid || s_tready))
        begin
            if (pending_samples.size() > 0 && !take_gap())
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= S_W'(pending_samples.pop_front());
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Result sink with random stalls.
    always @(posedge clk)
    begin
        m_tready <= rst_n && !take_gap();
    end

    // Monitor: tracks accepted samples and register writes, checks each result word.
    always @(posedge clk)
    begin : monitor
        calib_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                batch_len = cfg_data;
            if (s_tvalid && s_tready)
                track_sample(s_tdata[AXES*MAG_W-1:0]);
            if (m_tvalid && m_tready)
            begin
                if (calib_due.size() == 0)
                begin
                    $display("%0t: unexpected result word: expected none, actual %h user %b",
                             $time, m_tdata, m_tuser);
                    fail_count++;
                end
                else
                begin
                    want = calib_due.pop_front();
                    for (int a = 0; a < AXES; a++)
                    begin
                        if (m_tdata[MAG_W*a +: MAG_W] !== want.bias[a])
                        begin
                            $display("%0t: bias_%s mismatch: expected %0d, actual %0d",
                                     $time, axis_tag[a], $signed(want.bias[a]),
                                     $signed(m_tdata[MAG_W*a +: MAG_W]));
                            fail_count++;
                        end
                        if (m_tdata[AXES*MAG_W + SCALE_W*a +: SCALE_W] !== want.scale[a])
                        begin
                            $display("%0t: scale_%s mismatch: expected %0d, actual %0d",
                                     $time, axis_tag[a], want.scale[a],
                                     m_tdata[AXES*MAG_W + SCALE_W*a +: SCALE_W]);
                            fail_count++;
                        end
                    end
                    if (m_tuser !== want.degen)
                    begin
                        $display("%0t: degenerate mismatch: expected %b, actual %b",
                                 $time, want.degen, m_tuser);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Watchdog on cycles without any word moving on any channel.
    always @(posedge clk)
    begin
        cycle_count++;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    // Stimulus sequence.
    initial
    begin
        rearm_trackers();
        batch_len = COUNT_RESET;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Reset batch length: a few samples that close no batch.
        push_sample(32767, -32768, 0);
        push_sample(-1, 21845, -21846);
        push_sample(0, 0, 0);

        // Lowering the length below the fill ends the batch on the next sample;
        // single-sample batches are flat, including the most negative sample.
        set_batch(16'd1);
        push_sample(100, -200, 300);
        push_sample(-32768, -32768, -32768);
        push_sample(32767, 32767, 32767);

        // Two-sample batches: full range on two axes with a flat third, mixed
        // ranges, and a range of one count that still halves to zero.
        set_batch(16'd2);
        push_sample(32767, -32768, 5);
        push_sample(-32768, 32767, 5);
        push_sample(1000, -5, 7);
        push_sample(-1000, 5, 9);
        push_sample(-32768, 0, 2);
        push_sample(-32767, 1, 5);

        // A length of zero acts like one.
        set_batch(16'd0);
        push_sample(12, -12, 0);
        push_sample(-7, 7, 1);

        // Three-sample batch with every axis moving.
        set_batch(16'd3);
        push_sample(300, -300, 32767);
        push_sample(-100, 250, -32768);
        push_sample(0, 0, 0);

        // Random part: the longest length is left mid-batch and then lowered.
        set_batch(16'hFFFF);
        random_block(40);
        set_batch(16'd4);
        random_block(300);
        set_batch(16'd1);
        random_block(60);
        set_batch(16'd3);
        random_block(200);
        set_batch(16'd0);
        random_block(40);
        set_batch(16'd25);
        random_block(300);
        set_batch(16'($urandom_range(12, 2)));
        random_block(200);
        set_batch(16'd64);
        random_block(200);

        drain();
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/mic_pkg.sv
hw/rtl/mic_div.sv
hw/rtl/magnetometer_iron_calibration.sv
hw/rtl/mic_checker.sv
tb/tb.sv
